### rtl/core/ttt_pkg.sv
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int SLOTS   = 16;
  localparam int MAX_OUT = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int FIRE_W  = $clog2(MAX_OUT + 1);
  localparam int TIME_W  = 32;

  localparam logic [TIME_W-1:0] TIME_SAT = '1;

  // Task kinds
  localparam logic [2:0] KIND_ONCE     = 3'd0;
  localparam logic [2:0] KIND_INTERVAL = 3'd1;
  localparam logic [2:0] KIND_ASAP     = 3'd2;
  localparam logic [2:0] KIND_FRAME    = 3'd3;
  localparam logic [2:0] KIND_ABS      = 3'd4;

  // Operations
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FIRED    = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [2:0]        run_kind;
    logic [TIME_W-1:0] start_delay;
    logic [TIME_W-1:0] repeat_period;
    logic              threaded;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic       last_result;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } rsp_push_t;

  typedef struct packed {
    logic [TIME_W-1:0] due_time;
    logic [TIME_W-1:0] period;
    logic [2:0]        slot_kind;
    logic              finished;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_t             data;
  } slot_wr_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_SAT : s[TIME_W-1:0];
  endfunction

  function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+3:0] w;
    w = {4'b0000, s};
    return w[3:0];
  endfunction

endpackage

### rtl/core/ttt_if.sv
`timescale 1ns / 1ps

interface ttt_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  run_kind;
  logic [31:0] start_delay;
  logic [31:0] repeat_period;
  logic        threaded;
  logic [31:0] now_time;

  modport source (
    output valid, opcode, run_kind, start_delay, repeat_period, threaded, now_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, run_kind, start_delay, repeat_period, threaded, now_time,
    output ready
  );
endinterface

interface ttt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot_index;
  logic       last_result;

  modport source (
    output valid, status, slot_index, last_result,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, last_result,
    output ready
  );
endinterface

### rtl/core/ttt_slot_mem.sv
`timescale 1ns / 1ps

module ttt_slot_mem import ttt_pkg::*; (
  input  logic              clk_i,
  input  slot_wr_t          wr_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output slot_t             rd_data_o
);

  slot_t mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

### rtl/core/ttt_out_reg.sv
`timescale 1ns / 1ps

module ttt_out_reg import ttt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rsp_push_t push_i,
  output logic      push_ok_o,
  output logic      valid_o,
  input  logic      ready_i,
  output rsp_t      rsp_o
);

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign push_ok_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (push_i.valid && push_ok_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && push_ok_o) begin
      rsp_q <= push_i.rsp;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

### rtl/core/ttt_ctrl.sv
`timescale 1ns / 1ps

module ttt_ctrl import ttt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  input  logic              push_ok_i,
  output rsp_push_t         push_o,
  output slot_wr_t          mem_wr_o,
  output logic [SLOT_W-1:0] mem_rd_addr_o,
  input  slot_t             mem_rd_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;

  logic [2:0]        state_q, state_d;
  req_t              item_q;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [FIRE_W-1:0] fire_q, fire_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [CNT_W-1:0]  used_q, used_d;

  logic              reject, full;
  logic [TIME_W-1:0] add_due;
  logic              hit, stall;
  logic [CNT_W-1:0]  idx_inc;
  logic [FIRE_W-1:0] fire_inc;
  logic              scan_done;
  slot_t             upd;

  assign req_ready_o = (state_q == S_IDLE);

  // Add decision
  always_comb begin
    reject = (item_q.run_kind > KIND_ABS) ||
             ((item_q.run_kind == KIND_FRAME) && item_q.threaded);
    full   = (used_q >= CNT_W'(SLOTS));
    case (item_q.run_kind)
      KIND_ONCE, KIND_INTERVAL: add_due = sat_add(item_q.now_time, item_q.start_delay);
      KIND_ABS:                 add_due = item_q.start_delay;
      default:                  add_due = item_q.now_time;
    endcase
  end

  // Slot evaluation on the registered read data
  always_comb begin
    hit   = !mem_rd_data_i.finished && (item_q.now_time >= mem_rd_data_i.due_time);
    stall = hit && pend_q && !push_ok_i;
    upd   = mem_rd_data_i;
    case (mem_rd_data_i.slot_kind)
      KIND_FRAME:    upd.due_time = item_q.now_time;
      KIND_INTERVAL: upd.due_time = sat_add(mem_rd_data_i.due_time, mem_rd_data_i.period);
      default:       upd.finished = 1'b1;
    endcase
    idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
    fire_inc  = fire_q + FIRE_W'(hit);
    scan_done = (idx_inc >= used_q) || (fire_inc >= FIRE_W'(MAX_OUT));
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    fire_d        = fire_q;
    pend_d        = pend_q;
    pend_slot_d   = pend_slot_q;
    used_d        = used_q;
    push_o        = '0;
    mem_wr_o      = '0;
    mem_rd_addr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          idx_d  = '0;
          fire_d = '0;
          pend_d = 1'b0;
          if (req_i.opcode == OP_ADD) begin
            state_d = S_ADD;
          end else if (used_q == '0) begin
            state_d = S_END;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_ADD: begin
        push_o.rsp.last_result = 1'b1;
        push_o.rsp.slot_index  = '0;
        if (reject) begin
          push_o.rsp.status = ST_REJECTED;
        end else if (full) begin
          push_o.rsp.status = ST_FULL;
        end else begin
          push_o.rsp.status     = ST_ADDED;
          push_o.rsp.slot_index = slot_out(used_q[SLOT_W-1:0]);
        end
        if (push_ok_i) begin
          push_o.valid = 1'b1;
          state_d      = S_IDLE;
          if (!reject && !full) begin
            mem_wr_o.en             = 1'b1;
            mem_wr_o.addr           = used_q[SLOT_W-1:0];
            mem_wr_o.data.due_time  = add_due;
            mem_wr_o.data.period    = item_q.repeat_period;
            mem_wr_o.data.slot_kind = item_q.run_kind;
            mem_wr_o.data.finished  = 1'b0;
            used_d                  = used_q + CNT_W'(1);
          end
        end
      end

      S_SCAN: begin
        push_o.rsp.status      = ST_FIRED;
        push_o.rsp.slot_index  = slot_out(pend_slot_q);
        push_o.rsp.last_result = 1'b0;
        if (stall) begin
          // Hold the read address so the slot data stays put
          mem_rd_addr_o = idx_q;
        end else begin
          mem_rd_addr_o = idx_inc[SLOT_W-1:0];
          if (hit) begin
            mem_wr_o.en   = 1'b1;
            mem_wr_o.addr = idx_q;
            mem_wr_o.data = upd;
            push_o.valid  = pend_q;
            pend_d        = 1'b1;
            pend_slot_d   = idx_q;
            fire_d        = fire_inc;
          end
          idx_d = idx_inc[SLOT_W-1:0];
          if (scan_done) begin
            state_d = S_END;
          end
        end
      end

      S_END: begin
        push_o.rsp.last_result = 1'b1;
        if (pend_q) begin
          push_o.rsp.status     = ST_FIRED;
          push_o.rsp.slot_index = slot_out(pend_slot_q);
        end else begin
          push_o.rsp.status     = ST_IDLE;
          push_o.rsp.slot_index = '0;
        end
        if (push_ok_i) begin
          push_o.valid = 1'b1;
          pend_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      pend_q  <= 1'b0;
      idx_q   <= '0;
      fire_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      idx_q   <= idx_d;
      fire_q  <= fire_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    if (req_valid_i && req_ready_o) begin
      item_q <= req_i;
    end
  end

endmodule

### rtl/core/task_timer_table.sv
`timescale 1ns / 1ps
// Results: an add transaction is decided in the add state and offered through the output register;
//   a poll offers each fired slot once the next firing slot or the end of the walk is found,
//   and its last result from the end state once the walk is done.
// Throughput: one transaction at a time; a poll walks the used slots through the single
//   read port of the slot memory, one slot per cycle unless the output stalls.
// Reset: control state and the fill count clear at once; the slot memory is not cleared.
module task_timer_table import ttt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ttt_req_if.sink   req_i,
  ttt_rsp_if.source rsp_o
);

  req_t              req;
  rsp_t              rsp;
  rsp_push_t         push;
  logic              push_ok;
  slot_wr_t          mem_wr;
  logic [SLOT_W-1:0] mem_rd_addr;
  slot_t             mem_rd_data;

  // Gather the request payload into one word
  assign req.opcode        = req_i.opcode;
  assign req.run_kind      = req_i.run_kind;
  assign req.start_delay   = req_i.start_delay;
  assign req.repeat_period = req_i.repeat_period;
  assign req.threaded      = req_i.threaded;
  assign req.now_time      = req_i.now_time;

  // Sequencer: takes one transaction, writes add entries, walks the slots on poll.
  // A fired slot is held back until the next one is found, so the final result of a poll can carry
  // the last flag without a second pass.
  ttt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_i         (req),
    .push_ok_i     (push_ok),
    .push_o        (push),
    .mem_wr_o      (mem_wr),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  // Slot store: due time, period, kind and done flag per slot, one read and one write a cycle.
  // Only slots below the fill count are ever evaluated, so no clearing pass is needed.
  ttt_slot_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Output register: parts the sequencer from a stalled consumer
  ttt_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ok_o (push_ok),
    .valid_o   (rsp_o.valid),
    .ready_i   (rsp_o.ready),
    .rsp_o     (rsp)
  );

  assign rsp_o.status      = rsp.status;
  assign rsp_o.slot_index  = rsp.slot_index;
  assign rsp_o.last_result = rsp.last_result;

endmodule

### rtl/core/ttt_checker.sv
`timescale 1ns / 1ps

module ttt_checker import ttt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] status_i,
  input logic [3:0] slot_index_i,
  input logic       last_result_i
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(status_i) && $stable(slot_index_i) && $stable(last_result_i))
    else $error("result changed while stalled");

  // Status codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> status_i <= ST_IDLE)
    else $error("undefined status");

  // Rejected, full and nothing-due results name no slot and close their transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_REJECTED || status_i == ST_FULL || status_i == ST_IDLE)
      |-> slot_index_i == 4'd0 && last_result_i)
    else $error("slotless result malformed");

  // An added result is always the last result of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_ADDED |-> last_result_i)
    else $error("added result not last");

endmodule

bind task_timer_table ttt_checker u_ttt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .slot_index_i  (rsp_o.slot_index),
  .last_result_i (rsp_o.last_result)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the task timer table.
// An initial block queues a directed opening followed by random add/poll traffic; a clocked
// driver feeds it to the request channel, a clocked receiver takes the results and checks
// each one against a scoreboard filled by an in-bench model of the slot table.
module tb_top;
  import ttt_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT      = 150;    // accepted transactions before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_ITEMS   = 50;     // last transactions run with no idling at all
  localparam int DRAIN_CYCLES = 40;     // a full poll plus margin
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i;
  logic rst_ni;

  ttt_req_if req_if ();
  ttt_rsp_if rsp_if ();

  task_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the slot table, kept in step with accepted transactions
  logic [31:0] slot_due    [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic [2:0]  slot_type   [SLOTS];
  logic        slot_spent  [SLOTS];
  int unsigned slots_taken = 0;

  rsp_t awaited_rsp [$];   // results still owed by the block, oldest first
  req_t pending_req [$];   // transactions not yet offered to the block

  int n_add = 0, n_poll = 0, n_fired = 0, n_idle = 0, n_full = 0, n_reject = 0;
  int mismatches = 0;
  int cycle_cnt  = 0;

  int   accepted_cnt;
  int   rsp_cnt;
  int   gap_left;
  int   stall_left;
  int   hold_left;
  logic hold_done;
  logic quiet_tail;
  req_t launch_req;
  req_t taken_req;
  rsp_t want;

  // ---------------------------------------------------------------------------------------
  // Model of the table
  // ---------------------------------------------------------------------------------------

  // Saturating 32-bit sum of two timestamps
  function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic void owe_rsp(logic [2:0] st, int unsigned idx);
    rsp_t r;
    r.status      = st;
    r.slot_index  = idx[3:0];
    r.last_result = 1'b0;
    awaited_rsp = {awaited_rsp, r};
  endfunction

  // Advance the shadow table by one accepted transaction and queue the results it owes
  function automatic void table_step(req_t r);
    int unsigned fired;
    fired = 0;
    if (r.opcode == OP_ADD) begin
      n_add++;
      // Threaded every-frame and undefined kinds are turned away before the fill check
      if (r.run_kind > KIND_ABS || (r.run_kind == KIND_FRAME && r.threaded)) begin
        owe_rsp(ST_REJECTED, 0);
        n_reject++;
      end else if (slots_taken >= SLOTS) begin
        owe_rsp(ST_FULL, 0);
        n_full++;
      end else begin
        case (r.run_kind)
          KIND_ONCE, KIND_INTERVAL: slot_due[slots_taken] = clamp_sum(r.now_time, r.start_delay);
          KIND_ABS:                 slot_due[slots_taken] = r.start_delay;
          default:                  slot_due[slots_taken] = r.now_time;
        endcase
        slot_period[slots_taken] = r.repeat_period;
        slot_type[slots_taken]   = r.run_kind;
        slot_spent[slots_taken]  = 1'b0;
        owe_rsp(ST_ADDED, slots_taken);
        slots_taken++;
      end
    end else begin
      n_poll++;
      // Walk used slots in order; rearm or retire each one that is due
      for (int i = 0; i < slots_taken; i++) begin
        if (fired < MAX_OUT && !slot_spent[i] && r.now_time >= slot_due[i]) begin
          case (slot_type[i])
            KIND_FRAME:    slot_due[i]   = r.now_time;
            KIND_INTERVAL: slot_due[i]   = clamp_sum(slot_due[i], slot_period[i]);
            default:       slot_spent[i] = 1'b1;
          endcase
          owe_rsp(ST_FIRED, i);
          fired++;
        end
      end
      if (fired == 0) begin
        owe_rsp(ST_IDLE, 0);
        n_idle++;
      end else begin
        n_fired += fired;
      end
    end
    awaited_rsp[awaited_rsp.size() - 1].last_result = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Append a transaction to the tail of the stimulus queue
  function automatic void queue_req(req_t r);
    pending_req = {pending_req, r};
  endfunction

  function automatic req_t make_add(logic [2:0] k, logic [31:0] d, logic [31:0] p,
                                    logic thr, logic [31:0] now);
    req_t r;
    r.opcode        = OP_ADD;
    r.run_kind      = k;
    r.start_delay   = d;
    r.repeat_period = p;
    r.threaded      = thr;
    r.now_time      = now;
    return r;
  endfunction

  // Poll transactions carry random filler in the fields the block ignores
  function automatic req_t make_poll(logic [31:0] now, logic thr);
    req_t r;
    r.opcode        = OP_POLL;
    r.run_kind      = 3'($urandom_range(0, 7));
    r.start_delay   = $urandom();
    r.repeat_period = $urandom();
    r.threaded      = thr;
    r.now_time      = now;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Clock, reset, stimulus and the end of the run
  // ---------------------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    logic [31:0] t;
    logic [31:0] now;
    logic [2:0]  kind;
    logic [31:0] delay;
    logic [31:0] period;

    // Give the reset a clean falling edge once every process is waiting on it
    rst_ni = 1'b1;
    rst_ni <= 1'b0;

    // Directed opening: empty poll, every rejection, every kind, saturation on both sums
    queue_req(make_poll(32'd0, 1'b0));
    queue_req(make_add(3'd5, 32'd1, 32'd1, 1'b1, 32'd0));
    queue_req(make_add(3'd7, 32'd0, 32'd0, 1'b0, 32'd0));
    queue_req(make_add(KIND_FRAME, 32'd0, 32'd0, 1'b1, 32'd0));
    queue_req(make_add(KIND_ONCE, 32'd10, 32'd0, 1'b1, 32'd0));
    queue_req(make_add(KIND_INTERVAL, 32'd0, 32'd0, 1'b0, 32'd0));
    queue_req(make_add(KIND_ASAP, 32'd99, 32'd7, 1'b1, 32'd5));
    queue_req(make_add(KIND_FRAME, 32'd4, 32'd4, 1'b0, 32'd3));
    queue_req(make_add(KIND_ABS, 32'd20, 32'd0, 1'b0, 32'd1000));
    queue_req(make_add(KIND_ONCE, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd10));
    queue_req(make_add(KIND_INTERVAL, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 32'd0));
    queue_req(make_poll(32'd0, 1'b0));
    queue_req(make_poll(32'd4, 1'b1));
    queue_req(make_poll(32'd30, 1'b0));
    queue_req(make_poll(32'hFFFF_FFFF, 1'b0));
    queue_req(make_poll(32'hFFFF_FFFF, 1'b1));

    // Random traffic: a slowly advancing clock with the odd wild timestamp; adds fill the
    // remaining slots early, after which they exercise the full and rejected paths
    t = 32'd100;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      t   = t + $urandom_range(0, 12);
      now = ($urandom_range(0, 9) == 0) ? $urandom() : t;
      if ($urandom_range(0, 3) == 0) begin
        kind   = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        delay  = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60);
        period = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40);
        queue_req(make_add(kind, delay, period, 1'($urandom_range(0, 1)), now));
      end else begin
        queue_req(make_poll(now, 1'($urandom_range(0, 1))));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to go in and every owed result to come out
    while (pending_req.size() != 0 || req_if.valid || awaited_rsp.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds (%0d rejected, %0d on a full table) and %0d polls,",
             n_add, n_reject, n_full, n_poll);
    $display("  with %0d slot firings and %0d polls finding nothing due.", n_fired, n_idle);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Abort a run that has hung
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.opcode        <= OP_ADD;
      req_if.run_kind      <= KIND_ONCE;
      req_if.start_delay   <= '0;
      req_if.repeat_period <= '0;
      req_if.threaded      <= 1'b0;
      req_if.now_time      <= '0;
      gap_left             <= 0;
      accepted_cnt         <= 0;
      quiet_tail           <= 1'b0;
    end else begin
      // Predict from exactly what the block sampled on this edge
      if (req_if.valid && req_if.ready) begin
        taken_req = {req_if.opcode, req_if.run_kind, req_if.start_delay,
                     req_if.repeat_period, req_if.threaded, req_if.now_time};
        table_step(taken_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          req_if.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_req.size() > 0) begin
          launch_req = pending_req.pop_front();
          req_if.opcode        <= launch_req.opcode;
          req_if.run_kind      <= launch_req.run_kind;
          req_if.start_delay   <= launch_req.start_delay;
          req_if.repeat_period <= launch_req.repeat_period;
          req_if.threaded      <= launch_req.threaded;
          req_if.now_time      <= launch_req.now_time;
          req_if.valid         <= 1'b1;
          quiet_tail           <= (pending_req.size() < TAIL_ITEMS);
          // Idle in bursts, but only in some stretches of the run and never near its end
          if (!quiet_tail && (accepted_cnt % 64) < 40 && $urandom_range(0, 2) == 0)
            gap_left <= $urandom_range(1, 3);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Long hold-off of the receiver, so the block backs up and stalls its input
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      rsp_cnt      <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_cnt <= rsp_cnt + 1;
        if (awaited_rsp.size() == 0) begin
          $error("unexpected result: status %0d slot %0d last %0d",
                 rsp_if.status, rsp_if.slot_index, rsp_if.last_result);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("status", want.status, rsp_if.status);
          compare_field("slot_index", want.slot_index, rsp_if.slot_index);
          compare_field("last_result", want.last_result, rsp_if.last_result);
        end
      end
      // Hold ready low during the long hold-off or a short stall burst, else take results
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!quiet_tail && (rsp_cnt % 50) < 30 && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

endmodule
